// File: rtl/bdet_pkg.sv
// Shared types and constants for the button debounce and edge tracker.
// No dependencies; used by bdet_lane and button_debounce_edge_tracker_core.
package bdet_pkg;

    // Fixed field widths of the channels and the configuration register
    localparam int SAMPLE_W = 8;
    localparam int NOW_W    = 32;
    localparam int QUERY_W  = 3;
    localparam int MASK_W   = 8;
    localparam int DUR_W    = 32;
    localparam int PERIOD_W = 16;

    // Parameter defaults
    localparam int BUTTONS_DEF   = 8;
    localparam int TIME_BITS_DEF = 32;

    // Lockout period after reset, in ms
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

    // Per-button status handed from a lane to the top level
    typedef struct packed {
        logic pressed;   // press accepted on this transaction
        logic released;  // release accepted on this transaction
        logic held;      // held state after this transaction
    } bdet_lane_stat_t;

endpackage

// File: rtl/bdet_lane.sv
// One button lane: held flag, press time and lockout end with the
// debounce decision. Depends on bdet_pkg.
module bdet_lane #(
    parameter int TIME_BITS = bdet_pkg::TIME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          update,
    input  logic                          released_bit,
    input  logic [TIME_BITS-1:0]          now,
    input  logic [TIME_BITS-1:0]          period,
    output bdet_pkg::bdet_lane_stat_t     stat,
    output logic [TIME_BITS-1:0]          press_time_next
);
    import bdet_pkg::*;

    logic                 held_reg, held_next;
    logic [TIME_BITS-1:0] press_time_reg;
    logic [TIME_BITS-1:0] lockout_reg, lockout_next;
    logic                 window_open, do_press, do_release;

    // Change is looked at only once the lockout has run out
    always_comb begin
        window_open     = now > lockout_reg;
        do_release      = window_open && held_reg && released_bit;
        do_press        = window_open && !held_reg && !released_bit;
        held_next       = do_press || (held_reg && !do_release);
        press_time_next = do_press ? now : press_time_reg;
        lockout_next    = (do_press || do_release) ? now + period : lockout_reg;
        stat.pressed    = do_press;
        stat.released   = do_release;
        stat.held       = held_next;
    end

    // State advances once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= 1'b0;
            press_time_reg <= '0;
            lockout_reg    <= '0;
        end else if (update) begin
            held_reg       <= held_next;
            press_time_reg <= press_time_next;
            lockout_reg    <= lockout_next;
        end
    end

endmodule

// File: rtl/button_debounce_edge_tracker_core.sv
// Top level of the button debounce and edge tracker.
// Depends on bdet_pkg and bdet_lane.
//
//  channel | direction | ports                                        | accepted when
//  s_      | in        | sample_bits, now_ms, query_index             | s_valid && s_ready
//  m_      | out       | pressed/released/active_mask, held_duration  | m_valid && m_ready
//  cfg_    | in        | cfg_wdata (debounce_period)                  | cfg_we
//
// One transaction per cycle while the m_ side is not stalled; the result shows in the cycle after acceptance.
// All lanes decide in parallel from the input ports into the result register.
// s_ready is high while the result register is empty or being drained, so a
// stalled m_ side holds one result and blocks further input.
// Synchronous active-low reset clears held flags, lockouts and press times
// and sets the period to 50 ms.
module button_debounce_edge_tracker_core #(
    parameter int BUTTONS   = bdet_pkg::BUTTONS_DEF,
    parameter int TIME_BITS = bdet_pkg::TIME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [bdet_pkg::PERIOD_W-1:0] cfg_wdata,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdet_pkg::SAMPLE_W-1:0] s_sample_bits,
    input  logic [bdet_pkg::NOW_W-1:0]    s_now_ms,
    input  logic [bdet_pkg::QUERY_W-1:0]  s_query_index,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bdet_pkg::MASK_W-1:0]   m_pressed_mask,
    output logic [bdet_pkg::MASK_W-1:0]   m_released_mask,
    output logic [bdet_pkg::MASK_W-1:0]   m_active_mask,
    output logic [bdet_pkg::DUR_W-1:0]    m_held_duration
);
    import bdet_pkg::*;

    typedef logic [TIME_BITS-1:0] tval_t;

    logic [PERIOD_W-1:0] period_reg;
    tval_t               now, period;
    logic                accept;

    bdet_lane_stat_t     stat [BUTTONS];
    tval_t               ptime [BUTTONS];

    logic [MASK_W-1:0]   pmask_next, rmask_next, amask_next;
    logic [DUR_W-1:0]    dur_next;
    tval_t               sel_time;
    logic                sel_held;

    logic                m_valid_reg;
    logic [MASK_W-1:0]   pmask_reg, rmask_reg, amask_reg;
    logic [DUR_W-1:0]    dur_reg;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign now     = tval_t'(s_now_ms);
    assign period  = tval_t'(period_reg);

    // Lockout period register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            period_reg <= cfg_wdata;
        end
    end

    // One lane per button
    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        bdet_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .update         (accept),
            .released_bit   (s_sample_bits[g]),
            .now            (now),
            .period         (period),
            .stat           (stat[g]),
            .press_time_next(ptime[g])
        );
    end

    // Gather masks and select the queried button; unused buttons read as zero
    always_comb begin
        pmask_next = '0;
        rmask_next = '0;
        amask_next = '0;
        sel_time   = '0;
        sel_held   = 1'b0;
        for (int i = 0; i < BUTTONS; i++) begin
            pmask_next[i] = stat[i].pressed;
            rmask_next[i] = stat[i].released;
            amask_next[i] = stat[i].held;
            if (s_query_index == QUERY_W'(i)) begin
                sel_time = ptime[i];
                sel_held = stat[i].held;
            end
        end
        dur_next = sel_held ? DUR_W'(tval_t'(now - sel_time)) : '0;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pmask_reg <= pmask_next;
            rmask_reg <= rmask_next;
            amask_reg <= amask_next;
            dur_reg   <= dur_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pressed_mask  = pmask_reg;
    assign m_released_mask = rmask_reg;
    assign m_active_mask   = amask_reg;
    assign m_held_duration = dur_reg;

    // A button cannot both press and release on one transaction
    a_edge_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pressed_mask & m_released_mask) == '0)
        else $error("press and release flagged together");

    // A press leaves the button held, a release leaves it free
    a_edge_vs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pressed_mask & ~m_active_mask) == '0
                     && (m_released_mask & m_active_mask) == '0))
        else $error("edge mask disagrees with active mask");

    // An empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Every accepted transaction shows a result on the next cycle
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted transaction produced no result");

endmodule
